/* sv/i2c_eeprom_page_transfer_sequencer_defines.svh */
// Assertion macros for the I2C EEPROM page transfer sequencer checker.
// Needs clk_i and rst_ni in the scope of the module that expands them.
`ifndef I2C_EEPROM_PAGE_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_EEPROM_PAGE_TRANSFER_SEQUENCER_DEFINES_SVH

// Same-cycle implication.
`define IEPTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IEPTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/iepts_pkg.sv */
// Shared types, codes and constants of the I2C EEPROM page transfer sequencer.
// No dependencies.
package iepts_pkg;

  localparam int unsigned PAGE_BYTES = 8;  // 1 to 128
  localparam logic [6:0] DEV_ADDR_RESET = 7'd87;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_RESP  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_RESTART = 3'd1,
    OP_STOP    = 3'd2,
    OP_WRITE   = 3'd3,
    OP_RDACK   = 3'd4,
    OP_RDNACK  = 3'd5,
    OP_NONE    = 3'd6
  } bus_op_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CTRL,
    PH_ADDR,
    PH_NEED,
    PH_DATA,
    PH_RCTRL,
    PH_RBYTE
  } phase_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] mem_address;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       ack;
    logic [7:0] read_byte;
  } item_t;

  typedef struct packed {
    bus_op_e    op;
    logic [7:0] bus_byte;
    logic       read_valid;
    logic [7:0] read_data;
    logic       done_res;
  } res_t;

  // Up to four results of one item; last_idx is the index of the final one.
  typedef struct packed {
    res_t [3:0] entry;
    logic [1:0] last_idx;
  } res_blk_t;

  // Bit a set when memory address a opens a page.
  function automatic logic [255:0] page_start_map();
    logic [255:0] m;
    m = '0;
    for (int a = 0; a < 256; a += PAGE_BYTES) begin
      m[a] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [255:0] PAGE_START = page_start_map();

  function automatic res_t mk_res(input bus_op_e op, input logic [7:0] bval,
                                  input logic rvld, input logic [7:0] rdat,
                                  input logic done);
    res_t r;
    r.op         = op;
    r.bus_byte   = bval;
    r.read_valid = rvld;
    r.read_data  = rdat;
    r.done_res   = done;
    return r;
  endfunction

endpackage

/* sv/iepts_in_reg.sv */
// Input holding register of the sequencer: one item deep.
// Depends on iepts_pkg.
module iepts_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  iepts_pkg::item_t item_i,
  input  logic            take_i,
  output logic            valid_o,
  output iepts_pkg::item_t item_o
);

  logic             vld_q, vld_d;
  iepts_pkg::item_t item_q;

  // Free when empty or when the held item moves on this cycle.
  assign ready_o = !vld_q || take_i;

  always_comb begin
    vld_d = vld_q;
    if (valid_i && ready_o) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

/* sv/iepts_step.sv */
// Transfer state machine: sequencing state, device address register and the
// per-item result logic. Depends on iepts_pkg.
module iepts_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  input  logic                fire_i,
  input  iepts_pkg::item_t    item_i,
  output iepts_pkg::res_blk_t blk_o
);

  iepts_pkg::phase_e phase_q, phase_d;
  logic              dir_q, dir_d;
  logic [7:0]        addr_q, addr_d;
  logic [7:0]        left_q, left_d;
  logic [7:0]        pend_q, pend_d;
  logic [6:0]        dev_q;

  logic [7:0] wctrl, rctrl, a1, a2;
  logic       bnd1, bnd2;

  assign wctrl = {dev_q, 1'b0};
  assign rctrl = {dev_q, 1'b1};
  assign a1    = addr_q + 8'd1;
  assign a2    = addr_q + 8'd2;
  assign bnd1  = iepts_pkg::PAGE_START[a1];
  assign bnd2  = iepts_pkg::PAGE_START[a2];

  always_comb begin
    logic [2:0] n;
    logic       do_adv;
    phase_d = phase_q;
    dir_d   = dir_q;
    addr_d  = addr_q;
    left_d  = left_q;
    pend_d  = pend_q;
    n       = 3'd0;
    do_adv  = 1'b0;
    blk_o   = '0;
    if (fire_i) begin
      case (item_i.cmd)
        iepts_pkg::CMD_WRITE, iepts_pkg::CMD_READ: begin
          if (phase_q == iepts_pkg::PH_IDLE) begin
            dir_d  = item_i.cmd[0];
            addr_d = item_i.mem_address;
            left_d = item_i.byte_count;
            blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_START, 8'd0, 1'b0, 8'd0, 1'b0);
            n = n + 3'd1;
            blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_WRITE, wctrl, 1'b0, 8'd0, 1'b0);
            n = n + 3'd1;
            phase_d = iepts_pkg::PH_CTRL;
          end
        end
        iepts_pkg::CMD_DATA: begin
          if (phase_q == iepts_pkg::PH_NEED) begin
            pend_d = item_i.write_byte;
            blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_WRITE, item_i.write_byte,
                                                    1'b0, 8'd0, 1'b0);
            n = n + 3'd1;
            phase_d = iepts_pkg::PH_DATA;
          end
        end
        iepts_pkg::CMD_RESP: begin
          case (phase_q)
            iepts_pkg::PH_CTRL: begin
              if (item_i.ack) begin
                blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_WRITE, addr_q, 1'b0,
                                                        8'd0, 1'b0);
                n = n + 3'd1;
                phase_d = iepts_pkg::PH_ADDR;
              end else begin
                // Repeat the start along with the control byte.
                blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_START, 8'd0, 1'b0,
                                                        8'd0, 1'b0);
                n = n + 3'd1;
                blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_WRITE, wctrl, 1'b0,
                                                        8'd0, 1'b0);
                n = n + 3'd1;
              end
            end
            iepts_pkg::PH_ADDR: begin
              if (!item_i.ack) begin
                blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_WRITE, addr_q, 1'b0,
                                                        8'd0, 1'b0);
                n = n + 3'd1;
              end else if (dir_q) begin
                blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_RESTART, 8'd0, 1'b0,
                                                        8'd0, 1'b0);
                n = n + 3'd1;
                blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_WRITE, rctrl, 1'b0,
                                                        8'd0, 1'b0);
                n = n + 3'd1;
                phase_d = iepts_pkg::PH_RCTRL;
              end else if (left_q == 8'd0) begin
                blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_STOP, 8'd0, 1'b0,
                                                        8'd0, 1'b1);
                n = n + 3'd1;
                phase_d = iepts_pkg::PH_IDLE;
              end else begin
                phase_d = iepts_pkg::PH_NEED;
              end
            end
            iepts_pkg::PH_DATA: begin
              if (item_i.ack) begin
                do_adv = 1'b1;
              end else begin
                blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_WRITE, pend_q, 1'b0,
                                                        8'd0, 1'b0);
                n = n + 3'd1;
              end
            end
            iepts_pkg::PH_RCTRL: begin
              if (!item_i.ack) begin
                blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_RESTART, 8'd0, 1'b0,
                                                        8'd0, 1'b0);
                n = n + 3'd1;
                blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_WRITE, rctrl, 1'b0,
                                                        8'd0, 1'b0);
                n = n + 3'd1;
              end else if (left_q == 8'd0) begin
                blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_STOP, 8'd0, 1'b0,
                                                        8'd0, 1'b1);
                n = n + 3'd1;
                phase_d = iepts_pkg::PH_IDLE;
              end else begin
                // NACK the last byte of the block and of the page.
                blk_o.entry[n[1:0]] = iepts_pkg::mk_res(
                  (left_q == 8'd1 || bnd1) ? iepts_pkg::OP_RDNACK : iepts_pkg::OP_RDACK,
                  8'd0, 1'b0, 8'd0, 1'b0);
                n = n + 3'd1;
                phase_d = iepts_pkg::PH_RBYTE;
              end
            end
            iepts_pkg::PH_RBYTE: begin
              blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_NONE, 8'd0, 1'b1,
                                                      item_i.read_byte, 1'b0);
              n = n + 3'd1;
              do_adv = 1'b1;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase

      // Advance past a completed byte: close the block, re-address at a page
      // boundary, or go on with the next byte.
      if (do_adv) begin
        addr_d = a1;
        left_d = left_q - 8'd1;
        if (left_q == 8'd1) begin
          blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_STOP, 8'd0, 1'b0, 8'd0, 1'b1);
          n = n + 3'd1;
          phase_d = iepts_pkg::PH_IDLE;
        end else if (bnd1) begin
          blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_STOP, 8'd0, 1'b0, 8'd0, 1'b0);
          n = n + 3'd1;
          blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_START, 8'd0, 1'b0, 8'd0, 1'b0);
          n = n + 3'd1;
          blk_o.entry[n[1:0]] = iepts_pkg::mk_res(iepts_pkg::OP_WRITE, wctrl, 1'b0, 8'd0, 1'b0);
          n = n + 3'd1;
          phase_d = iepts_pkg::PH_CTRL;
        end else if (dir_q) begin
          blk_o.entry[n[1:0]] = iepts_pkg::mk_res(
            (left_q == 8'd2 || bnd2) ? iepts_pkg::OP_RDNACK : iepts_pkg::OP_RDACK,
            8'd0, 1'b0, 8'd0, 1'b0);
          n = n + 3'd1;
          phase_d = iepts_pkg::PH_RBYTE;
        end else begin
          phase_d = iepts_pkg::PH_NEED;
        end
      end

      if (n == 3'd0) begin
        blk_o.entry[0] = iepts_pkg::mk_res(iepts_pkg::OP_NONE, 8'd0, 1'b0, 8'd0, 1'b0);
        n = 3'd1;
      end
    end
    blk_o.last_idx = 2'(n - 3'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= iepts_pkg::PH_IDLE;
      dir_q   <= 1'b0;
      addr_q  <= 8'd0;
      left_q  <= 8'd0;
      pend_q  <= 8'd0;
      dev_q   <= iepts_pkg::DEV_ADDR_RESET;
    end else begin
      phase_q <= phase_d;
      dir_q   <= dir_d;
      addr_q  <= addr_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        dev_q <= cfg_wdata_i;
      end
    end
  end

endmodule

/* sv/iepts_res_buf.sv */
// Result register of the sequencer: holds the one to four results of an item
// and hands them out one per transfer. Depends on iepts_pkg.
module iepts_res_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  iepts_pkg::res_blk_t blk_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output iepts_pkg::res_t     res_o,
  output logic                last_o
);

  iepts_pkg::res_blk_t blk_q;
  logic                vld_q, vld_d;
  logic [1:0]          idx_q, idx_d;

  assign last_o  = (idx_q == blk_q.last_idx);
  assign valid_o = vld_q;
  assign res_o   = blk_q.entry[idx_q];
  // Refill when empty or in the cycle that the final result leaves.
  assign free_o  = !vld_q || (ready_i && last_o);

  always_comb begin
    vld_d = vld_q;
    idx_d = idx_q;
    if (load_i) begin
      vld_d = 1'b1;
      idx_d = 2'd0;
    end else if (vld_q && ready_i) begin
      if (last_o) begin
        vld_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      blk_q <= blk_i;
    end
  end

endmodule

/* sv/i2c_eeprom_page_transfer_sequencer.sv */
// Top level of the I2C EEPROM page transfer sequencer.
// Depends on iepts_pkg, iepts_in_reg, iepts_step and iepts_res_buf.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-----------------------------------------
//   config  | cfg_we_i                   | cfg_wdata_i (device address)
//   input   | in_valid_i / in_ready_o    | cmd, mem_address, byte_count, write_byte,
//           |                            | ack, read_byte
//   output  | out_valid_o / out_ready_i  | bus_op, bus_byte, read_valid, read_data,
//           |                            | done_res, last
//
// An item is taken into the input register, worked through the state machine and
// its one to four results land in the result register.
// The result register hands out one result per cycle while the output is ready;
// single-result items flow one per cycle while the output is ready.
// A stalled output holds its result; the input register keeps taking one item.
// Reset (rst_ni low, asynchronous) returns to idle with device address 87.
module i2c_eeprom_page_transfer_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] mem_address_i,
  input  logic [7:0] byte_count_i,
  input  logic [7:0] write_byte_i,
  input  logic       ack_i,
  input  logic [7:0] read_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] bus_op_o,
  output logic [7:0] bus_byte_o,
  output logic       read_valid_o,
  output logic [7:0] read_data_o,
  output logic       done_res_o,
  output logic       last_o
);

  iepts_pkg::item_t    item_in, item_held;
  iepts_pkg::res_blk_t blk;
  iepts_pkg::res_t     res;
  logic                held_vld, buf_free, fire;

  assign item_in.cmd         = iepts_pkg::cmd_e'(cmd_i);
  assign item_in.mem_address = mem_address_i;
  assign item_in.byte_count  = byte_count_i;
  assign item_in.write_byte  = write_byte_i;
  assign item_in.ack         = ack_i;
  assign item_in.read_byte   = read_byte_i;

  assign fire = held_vld && buf_free;

  iepts_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (item_in),
    .take_i  (fire),
    .valid_o (held_vld),
    .item_o  (item_held)
  );

  iepts_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item_held),
    .blk_o       (blk)
  );

  iepts_res_buf u_res_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .blk_i   (blk),
    .free_o  (buf_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res),
    .last_o  (last_o)
  );

  assign bus_op_o     = res.op;
  assign bus_byte_o   = res.bus_byte;
  assign read_valid_o = res.read_valid;
  assign read_data_o  = res.read_data;
  assign done_res_o   = res.done_res;

endmodule

/* sv/iepts_checker.sv */
// Port-level checker for the I2C EEPROM page transfer sequencer, bound to the top.
// Depends on iepts_pkg and i2c_eeprom_page_transfer_sequencer_defines.svh.
`include "i2c_eeprom_page_transfer_sequencer_defines.svh"

module iepts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic [6:0] cfg_wdata_i,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] cmd_i,
  input logic [7:0] mem_address_i,
  input logic [7:0] byte_count_i,
  input logic [7:0] write_byte_i,
  input logic       ack_i,
  input logic [7:0] read_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] bus_op_o,
  input logic [7:0] bus_byte_o,
  input logic       read_valid_o,
  input logic [7:0] read_data_o,
  input logic       done_res_o,
  input logic       last_o
);

  // A stalled result holds.
  `IEPTS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(bus_op_o) && $stable(bus_byte_o) && $stable(read_data_o) && $stable(last_o), "stalled result changed")

  // A read byte travels alone, with no bus primitive.
  `IEPTS_ASSERT_NOW(a_read_alone, out_valid_o && read_valid_o, bus_op_o == iepts_pkg::OP_NONE && bus_byte_o == 8'd0 && !done_res_o, "read byte mixed with bus primitive")

  // The final stop closes the item's results.
  `IEPTS_ASSERT_NOW(a_done_stop, out_valid_o && done_res_o, bus_op_o == iepts_pkg::OP_STOP && last_o, "done without final stop")

  // Only byte writes carry a bus byte.
  `IEPTS_ASSERT_NOW(a_byte_write_only, out_valid_o && bus_op_o != iepts_pkg::OP_WRITE, bus_byte_o == 8'd0, "bus byte on a non-write primitive")

  // No unused operation code reaches the bus.
  `IEPTS_ASSERT_NOW(a_op_code, out_valid_o, bus_op_o != 3'd7, "unused bus operation code")

endmodule

bind i2c_eeprom_page_transfer_sequencer iepts_checker u_iepts_checker (.*);

/* tb/i2c_eeprom_page_transfer_sequencer_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the I2C EEPROM page transfer sequencer.
// Drives block transfers and bus responses, predicts each bus primitive in order
// and checks every result; depends on iepts_pkg and the sequencer RTL.
module i2c_eeprom_page_transfer_sequencer_tb;

  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    iepts_pkg::res_t res;
    logic            last;
  } bus_res_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [6:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] cmd_i;
  logic [7:0] mem_address_i;
  logic [7:0] byte_count_i;
  logic [7:0] write_byte_i;
  logic       ack_i;
  logic [7:0] read_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] bus_op_o;
  logic [7:0] bus_byte_o;
  logic       read_valid_o;
  logic [7:0] read_data_o;
  logic       done_res_o;
  logic       last_o;

  // Sequencer state as predicted from the accepted transfers.
  iepts_pkg::phase_e seq_phase;
  logic              seq_read;
  logic [7:0]        seq_addr;
  logic [7:0]        seq_left;
  logic [7:0]        seq_pending;
  logic [6:0]        dev_addr;

  bus_res_t   expected_ops[$];
  int         mismatches;
  int         driven_items;
  bit         valid_held;
  bit         idle_on;
  bit         hold_req;

  i2c_eeprom_page_transfer_sequencer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .mem_address_i(mem_address_i),
    .byte_count_i (byte_count_i),
    .write_byte_i (write_byte_i),
    .ack_i        (ack_i),
    .read_byte_i  (read_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bus_op_o     (bus_op_o),
    .bus_byte_o   (bus_byte_o),
    .read_valid_o (read_valid_o),
    .read_data_o  (read_data_o),
    .done_res_o   (done_res_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void push_op(input iepts_pkg::bus_op_e op, input logic [7:0] bval,
                                  input logic rvld, input logic [7:0] rdat,
                                  input logic done);
    bus_res_t e;
    e.res.op         = op;
    e.res.bus_byte   = bval;
    e.res.read_valid = rvld;
    e.res.read_data  = rdat;
    e.res.done_res   = done;
    e.last           = 1'b0;
    expected_ops.push_back(e);
  endfunction

  function automatic logic page_edge(input logic [7:0] a);
    return (a % iepts_pkg::PAGE_BYTES) == 0;
  endfunction

  function automatic void seq_open_address();
    push_op(iepts_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
    push_op(iepts_pkg::OP_WRITE, {dev_addr, 1'b0}, 1'b0, 8'h00, 1'b0);
    seq_phase = iepts_pkg::PH_CTRL;
  endfunction

  function automatic void seq_restart_read();
    push_op(iepts_pkg::OP_RESTART, 8'h00, 1'b0, 8'h00, 1'b0);
    push_op(iepts_pkg::OP_WRITE, {dev_addr, 1'b1}, 1'b0, 8'h00, 1'b0);
    seq_phase = iepts_pkg::PH_RCTRL;
  endfunction

  function automatic void seq_issue_read();
    logic [7:0] nxt;
    nxt = seq_addr + 8'd1;
    // NACK closes a page and the whole block
    if (seq_left == 8'd1 || page_edge(nxt)) begin
      push_op(iepts_pkg::OP_RDNACK, 8'h00, 1'b0, 8'h00, 1'b0);
    end else begin
      push_op(iepts_pkg::OP_RDACK, 8'h00, 1'b0, 8'h00, 1'b0);
    end
    seq_phase = iepts_pkg::PH_RBYTE;
  endfunction

  function automatic void seq_final_stop();
    push_op(iepts_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 1'b1);
    seq_phase = iepts_pkg::PH_IDLE;
  endfunction

  function automatic void seq_advance();
    seq_addr = seq_addr + 8'd1;
    seq_left = seq_left - 8'd1;
    if (seq_left == 8'd0) begin
      seq_final_stop();
    end else if (page_edge(seq_addr)) begin
      push_op(iepts_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
      seq_open_address();
    end else if (seq_read) begin
      seq_issue_read();
    end else begin
      seq_phase = iepts_pkg::PH_NEED;
    end
  endfunction

  function automatic void predict_bus_ops(input iepts_pkg::item_t it);
    int                base;
    iepts_pkg::phase_e was;
    bus_res_t          e;
    base = expected_ops.size();
    was  = seq_phase;
    case (it.cmd)
      iepts_pkg::CMD_WRITE, iepts_pkg::CMD_READ: begin
        if (seq_phase == iepts_pkg::PH_IDLE) begin
          seq_read = (it.cmd == iepts_pkg::CMD_READ);
          seq_addr = it.mem_address;
          seq_left = it.byte_count;
          seq_open_address();
        end
      end
      iepts_pkg::CMD_DATA: begin
        if (seq_phase == iepts_pkg::PH_NEED) begin
          seq_pending = it.write_byte;
          push_op(iepts_pkg::OP_WRITE, seq_pending, 1'b0, 8'h00, 1'b0);
          seq_phase = iepts_pkg::PH_DATA;
        end
      end
      default: begin
        case (seq_phase)
          iepts_pkg::PH_CTRL: begin
            if (it.ack) begin
              push_op(iepts_pkg::OP_WRITE, seq_addr, 1'b0, 8'h00, 1'b0);
              seq_phase = iepts_pkg::PH_ADDR;
            end else begin
              seq_open_address();
            end
          end
          iepts_pkg::PH_ADDR: begin
            if (!it.ack) begin
              push_op(iepts_pkg::OP_WRITE, seq_addr, 1'b0, 8'h00, 1'b0);
            end else if (seq_read) begin
              seq_restart_read();
            end else if (seq_left == 8'd0) begin
              seq_final_stop();
            end else begin
              seq_phase = iepts_pkg::PH_NEED;
            end
          end
          iepts_pkg::PH_DATA: begin
            if (it.ack) begin
              seq_advance();
            end else begin
              push_op(iepts_pkg::OP_WRITE, seq_pending, 1'b0, 8'h00, 1'b0);
            end
          end
          iepts_pkg::PH_RCTRL: begin
            if (!it.ack) begin
              seq_restart_read();
            end else if (seq_left == 8'd0) begin
              seq_final_stop();
            end else begin
              seq_issue_read();
            end
          end
          iepts_pkg::PH_RBYTE: begin
            push_op(iepts_pkg::OP_NONE, 8'h00, 1'b1, it.read_byte, 1'b0);
            seq_advance();
          end
          default: ;
        endcase
      end
    endcase
    if (expected_ops.size() != base || seq_phase != was) driven_items++;
    if (expected_ops.size() == base) push_op(iepts_pkg::OP_NONE, 8'h00, 1'b0, 8'h00, 1'b0);
    e = expected_ops.pop_back();
    e.last = 1'b1;
    expected_ops.push_back(e);
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic iepts_pkg::item_t random_item();
    iepts_pkg::item_t it;
    it.cmd         = iepts_pkg::cmd_e'($urandom_range(0, 3));
    it.mem_address = 8'($urandom);
    it.byte_count  = 8'($urandom);
    it.write_byte  = 8'($urandom);
    it.ack         = 1'($urandom_range(0, 1));
    it.read_byte   = 8'($urandom);
    return it;
  endfunction

  task automatic drop_valid();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
    end
  endtask

  task automatic send_item(input iepts_pkg::item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      drop_valid();
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    valid_held    = 1'b1;
    cmd_i         <= it.cmd;
    mem_address_i <= it.mem_address;
    byte_count_i  <= it.byte_count;
    write_byte_i  <= it.write_byte;
    ack_i         <= it.ack;
    read_byte_i   <= it.read_byte;
    do @(posedge clk_i); while (!in_ready_o);
    predict_bus_ops(it);
  endtask

  task automatic begin_block(input iepts_pkg::cmd_e c, input logic [7:0] mem,
                             input logic [7:0] cnt);
    iepts_pkg::item_t it;
    it             = random_item();
    it.cmd         = c;
    it.mem_address = mem;
    it.byte_count  = cnt;
    send_item(it);
  endtask

  task automatic respond(input logic ack, input logic [7:0] rbyte);
    iepts_pkg::item_t it;
    it           = random_item();
    it.cmd       = iepts_pkg::CMD_RESP;
    it.ack       = ack;
    it.read_byte = rbyte;
    send_item(it);
  endtask

  task automatic put_byte(input logic [7:0] wbyte);
    iepts_pkg::item_t it;
    it            = random_item();
    it.cmd        = iepts_pkg::CMD_DATA;
    it.write_byte = wbyte;
    send_item(it);
  endtask

  // Play the bus side until the block transfer closes.
  task automatic finish_block(input int nack_pct, input int noise_pct);
    iepts_pkg::item_t it;
    while (seq_phase != iepts_pkg::PH_IDLE) begin
      it = random_item();
      if ($urandom_range(0, 99) >= noise_pct) begin
        if (seq_phase == iepts_pkg::PH_NEED) begin
          it.cmd = iepts_pkg::CMD_DATA;
        end else begin
          it.cmd = iepts_pkg::CMD_RESP;
          it.ack = ($urandom_range(0, 99) >= nack_pct);
        end
      end
      send_item(it);
    end
  endtask

  task automatic drive_block(input iepts_pkg::cmd_e c, input logic [7:0] mem,
                             input logic [7:0] cnt, input int nack_pct,
                             input int noise_pct);
    begin_block(c, mem, cnt);
    finish_block(nack_pct, noise_pct);
  endtask

  task automatic wait_drained();
    drop_valid();
    while (expected_ops.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_device_address(input logic [6:0] value);
    wait_drained();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dev_addr = value;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_zero_count();
    begin_block(iepts_pkg::CMD_WRITE, 8'hFF, 8'd0);
    respond(1'b1, 8'h00);
    respond(1'b1, 8'hFF);
    begin_block(iepts_pkg::CMD_READ, 8'h00, 8'd0);
    respond(1'b1, 8'h00);
    respond(1'b1, 8'h00);
    respond(1'b1, 8'h00);
  endtask

  // NACK on control, address and data bytes; the block wraps 255 to 0 on a page edge.
  task automatic test_write_retry_wrap();
    begin_block(iepts_pkg::CMD_WRITE, 8'hFF, 8'd2);
    respond(1'b0, 8'h00);
    respond(1'b1, 8'h00);
    respond(1'b0, 8'h00);
    respond(1'b1, 8'h00);
    put_byte(8'hFF);
    respond(1'b0, 8'h00);
    respond(1'b1, 8'h00);
    respond(1'b1, 8'h00);
    respond(1'b1, 8'h00);
    put_byte(8'h00);
    respond(1'b1, 8'h00);
  endtask

  task automatic test_read_page_nack();
    begin_block(iepts_pkg::CMD_READ, 8'h06, 8'd3);
    respond(1'b1, 8'h00);
    respond(1'b1, 8'h00);
    respond(1'b0, 8'h00);
    respond(1'b1, 8'h00);
    respond(1'b0, 8'hFF);
    respond(1'b1, 8'h00);
    respond(1'b1, 8'h00);
    respond(1'b1, 8'h00);
    respond(1'b1, 8'h00);
    respond(1'b0, 8'hA5);
  endtask

  task automatic test_out_of_phase();
    respond(1'b1, 8'h00);
    begin_block(iepts_pkg::CMD_WRITE, 8'h03, 8'd1);
    begin_block(iepts_pkg::CMD_READ, 8'h10, 8'd4);
    put_byte(8'h33);
    respond(1'b1, 8'h00);
    respond(1'b1, 8'h00);
    respond(1'b1, 8'h00);
    put_byte(8'h5A);
    respond(1'b1, 8'h00);
  endtask

  task automatic test_config_extremes();
    set_device_address(7'd0);
    drive_block(iepts_pkg::CMD_READ, 8'($urandom), 8'd2, 10, 0);
    set_device_address(7'd127);
    drive_block(iepts_pkg::CMD_WRITE, 8'($urandom), 8'd3, 10, 0);
  endtask

  // Receiver holds off while a multi-page read keeps the input side busy.
  task automatic test_long_read_hold();
    wait_drained();
    hold_req = 1'b1;
    drive_block(iepts_pkg::CMD_READ, 8'($urandom), 8'd24, 0, 0);
  endtask

  task automatic test_random_mix(input int count);
    int               goal;
    int               pick;
    iepts_pkg::item_t it;
    logic [7:0]       cnt;
    goal = driven_items + count;
    while (driven_items < goal) begin
      if ($urandom_range(0, 9) == 0) set_device_address(7'($urandom_range(0, 127)));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          it = random_item();
          // keep transfers opened by noise short
          if (seq_phase == iepts_pkg::PH_IDLE) it.byte_count = it.byte_count & 8'h0F;
          send_item(it);
        end
        finish_block(20, 10);
      end else begin
        pick = int'($urandom_range(0, 19));
        if (pick == 0) cnt = 8'd0;
        else if (pick <= 2) cnt = 8'($urandom_range(9, 24));
        else cnt = 8'($urandom_range(1, 8));
        drive_block(iepts_pkg::cmd_e'($urandom_range(0, 1)), 8'($urandom), cnt,
                    int'($urandom_range(0, 25)), int'($urandom_range(0, 8)));
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin : receiver
    int stall;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      stall = 0;
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 4);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    bus_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_ops.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, actual op %0d byte %0d",
                 $time, bus_op_o, bus_byte_o);
      end else begin
        want = expected_ops.pop_front();
        check_field("bus_op", 32'(want.res.op), 32'(bus_op_o));
        check_field("bus_byte", 32'(want.res.bus_byte), 32'(bus_byte_o));
        check_field("read_valid", 32'(want.res.read_valid), 32'(read_valid_o));
        check_field("read_data", 32'(want.res.read_data), 32'(read_data_o));
        check_field("done_res", 32'(want.res.done_res), 32'(done_res_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    cmd_i         <= '0;
    mem_address_i <= '0;
    byte_count_i  <= '0;
    write_byte_i  <= '0;
    ack_i         <= 1'b0;
    read_byte_i   <= '0;
    seq_phase     = iepts_pkg::PH_IDLE;
    seq_read      = 1'b0;
    seq_addr      = '0;
    seq_left      = '0;
    seq_pending   = '0;
    dev_addr      = iepts_pkg::DEV_ADDR_RESET;
    mismatches    = 0;
    driven_items  = 0;
    valid_held    = 1'b0;
    hold_req      = 1'b0;
    idle_on       = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_count();
    test_write_retry_wrap();
    test_read_page_nack();
    test_out_of_phase();
    test_config_extremes();
    test_long_read_hold();
    test_random_mix(130);
    wait_drained();
    idle_on = 1'b0;
    test_random_mix(30);

    wait_drained();
    repeat (4 * DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
